[rtl/core/efad_pkg.sv]
// Shared constants, types and helpers for the encoder frame angle decoder.
`default_nettype none

package efad_pkg;

   localparam int NUM_READINGS = 8;
   localparam int SLOT_W       = $clog2(NUM_READINGS);
   localparam int BYTE_W       = 8;
   localparam int DATA_BYTES   = 24;
   localparam int ADDR_W       = $clog2(DATA_BYTES);
   localparam int POS_W        = 5;
   localparam int COUNT_W      = 24;
   localparam int VALUE_W      = 34;
   localparam int SCALE_W      = 11;
   localparam int PROD_W       = COUNT_W + SCALE_W;

   localparam logic [POS_W-1:0]  FRAME_LAST    = POS_W'(25);
   localparam logic [BYTE_W-1:0] RECORD_HEADER = 8'd80;

   // counts above the limit and below the span wrap to negative angles
   localparam logic [COUNT_W-1:0]        WRAP_LIMIT = 24'd5000000;
   localparam logic signed [COUNT_W:0]   WRAP_SPAN  = 25'sd10000000;
   localparam logic signed [SCALE_W-1:0] SCALE_LOW  = 11'sd405;
   localparam logic signed [SCALE_W-1:0] SCALE_HIGH = 11'sd810;

   localparam logic [1:0] SEL_LAST = 2'd2;

   typedef struct packed {
      logic done;     // checksum byte transferred
      logic csum_ok;
      logic rec;
   } frame_evt_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DRAIN,
      ST_WRAP,
      ST_MUL,
      ST_SEND
   } emit_state_type;

   // output slot to reading: 0,1,2,3,6,7,4,5
   function automatic logic [SLOT_W-1:0] slot_reading(input logic [SLOT_W-1:0] slot);
      slot_reading = {slot[2], slot[1] ^ slot[2], slot[0]};
   endfunction

endpackage

`default_nettype wire

[rtl/core/efad_if.sv]
// Valid/ready channel interfaces for byte input and angle results.
`default_nettype none

interface efad_req_if;
   import efad_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface efad_rsp_if;
   import efad_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [SLOT_W-1:0]         angle_index;
   logic signed [VALUE_W-1:0] angle_value;
   logic                      record_flag;
   logic                      checksum_error;
   logic                      last_result;

   modport source (output valid, output angle_index, output angle_value,
                   output record_flag, output checksum_error, output last_result,
                   input ready);
   modport sink   (input valid, input angle_index, input angle_value,
                   input record_flag, input checksum_error, input last_result,
                   output ready);
endinterface

`default_nettype wire

[rtl/core/efad_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module efad_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 24
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/efad_intake.sv]
// Frame intake: byte position, running XOR, header capture and store writes.
`default_nettype none

module efad_intake (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire logic [efad_pkg::BYTE_W-1:0]    data_byte,
   input  wire logic                           frame_start,
   output logic                                wr_en,
   output logic      [efad_pkg::ADDR_W-1:0]    wr_addr,
   output logic      [efad_pkg::BYTE_W-1:0]    wr_data,
   output efad_pkg::frame_evt_type             frame_evt
);
   import efad_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic [BYTE_W-1:0] header_ff, header_in;

   always_comb begin
      pos_in         = pos_ff;
      xor_in         = xor_ff;
      header_in      = header_ff;
      wr_en          = 1'b0;
      wr_addr        = ADDR_W'(pos_ff - POS_W'(1));
      wr_data        = data_byte;
      frame_evt      = '0;
      frame_evt.rec  = (header_ff == RECORD_HEADER);
      frame_evt.csum_ok = (xor_ff == data_byte);
      if (accept) begin
         if (frame_start) begin
            header_in = data_byte;
            xor_in    = '0;
            pos_in    = POS_W'(1);
         end else if (pos_ff inside {[1:DATA_BYTES]}) begin
            wr_en  = 1'b1;
            xor_in = xor_ff ^ data_byte;
            pos_in = pos_ff + POS_W'(1);
         end else begin
            // stray byte or checksum byte: back to waiting for a header
            pos_in         = '0;
            frame_evt.done = (pos_ff == FRAME_LAST);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         xor_ff    <= '0;
         header_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         xor_ff    <= xor_in;
         header_ff <= header_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/efad_emit.sv]
// Result sequencer: reads each count from the store, wraps, scales and sends it; a bad checksum gives one error result.
`default_nettype none

module efad_emit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  efad_pkg::frame_evt_type          frame_evt,
   output logic                             rd_en,
   output logic      [efad_pkg::ADDR_W-1:0] rd_addr,
   input  wire logic [efad_pkg::BYTE_W-1:0] rd_data,
   output logic                             busy,
   efad_rsp_if.source                       rsp_bus
);
   import efad_pkg::*;

   emit_state_type state_ff, state_in;

   logic [SLOT_W-1:0]          slot_ff;
   logic [1:0]                 sel_ff;
   logic                       err_ff;
   logic                       rec_ff;
   logic                       rd_pend_ff;
   logic [COUNT_W-1:0]         cnt_ff;
   logic signed [COUNT_W-1:0]  wrap_ff;
   logic signed [VALUE_W-1:0]  value_ff;

   logic [SLOT_W-1:0]          reading;
   logic                       slot_last;
   logic                       res_last;
   logic                       send_done;
   logic signed [COUNT_W:0]    wrap_c;
   logic signed [SCALE_W-1:0]  scale_c;
   logic signed [PROD_W-1:0]   mul_c;

   assign reading   = slot_reading(slot_ff);
   assign slot_last = (slot_ff == SLOT_W'(NUM_READINGS - 1));
   assign res_last  = err_ff | slot_last;
   assign send_done = (state_ff == ST_SEND) && rsp_bus.ready;

   assign wrap_c  = (cnt_ff > WRAP_LIMIT) ? ($signed({1'b0, cnt_ff}) - WRAP_SPAN)
                                          : $signed({1'b0, cnt_ff});
   assign scale_c = reading[2] ? SCALE_HIGH : SCALE_LOW;
   assign mul_c   = PROD_W'(wrap_ff) * PROD_W'(scale_c);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (frame_evt.done) begin
               state_in = frame_evt.csum_ok ? ST_FETCH : ST_SEND;
            end
         end
         ST_FETCH: begin
            if (sel_ff == SEL_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_WRAP;
         ST_WRAP:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_SEND;
         ST_SEND: begin
            if (rsp_bus.ready) begin
               state_in = res_last ? ST_IDLE : ST_FETCH;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      rd_en         = 1'b0;
      rd_addr       = ADDR_W'({reading, 1'b0}) + ADDR_W'(reading) + ADDR_W'(sel_ff);
      busy          = 1'b1;
      rsp_bus.valid = 1'b0;
      case (state_ff)
         ST_IDLE:  busy = 1'b0;
         ST_FETCH: rd_en = 1'b1;
         ST_SEND:  rsp_bus.valid = 1'b1;
         default:  busy = 1'b1;
      endcase
   end

   assign rsp_bus.angle_index    = slot_ff;
   assign rsp_bus.angle_value    = value_ff;
   assign rsp_bus.record_flag    = rec_ff;
   assign rsp_bus.checksum_error = err_ff;
   assign rsp_bus.last_result    = res_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_pend_ff <= 1'b0;
         slot_ff    <= '0;
         sel_ff     <= '0;
         err_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= rd_en;
         if (state_ff == ST_IDLE && frame_evt.done) begin
            slot_ff <= '0;
            sel_ff  <= '0;
            err_ff  <= ~frame_evt.csum_ok;
         end
         if (state_ff == ST_FETCH) begin
            sel_ff <= (sel_ff == SEL_LAST) ? 2'd0 : sel_ff + 2'd1;
         end
         if (send_done && !res_last) begin
            slot_ff <= slot_ff + SLOT_W'(1);
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && frame_evt.done) begin
         rec_ff   <= frame_evt.rec;
         value_ff <= '0;
      end
      if (rd_pend_ff) begin
         // big-endian: shift in one byte per read
         cnt_ff <= {cnt_ff[COUNT_W-BYTE_W-1:0], rd_data};
      end
      if (state_ff == ST_WRAP) begin
         wrap_ff <= wrap_c[COUNT_W-1:0];
      end
      if (state_ff == ST_MUL) begin
         value_ff <= $signed(mul_c[VALUE_W-1:0]);
      end
   end

   a_evt_only_idle: assert property (@(posedge clock) disable iff (reset)
      frame_evt.done |-> (state_ff == ST_IDLE))
      else $error("frame end seen while results still pending");

   a_rd_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (rd_addr < ADDR_W'(DATA_BYTES)))
      else $error("store read out of range");

   a_next_slot: assert property (@(posedge clock) disable iff (reset)
      (send_done && !res_last) |=>
         (state_ff == ST_FETCH && slot_ff == $past(slot_ff) + SLOT_W'(1)))
      else $error("slot did not advance after transfer");

   a_err_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && err_ff) |-> (slot_ff == '0 && value_ff == '0))
      else $error("error result carries data");

   a_fetch_aligned: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SEND) && rsp_bus.ready && !res_last) |=> (sel_ff == 2'd0))
      else $error("byte select misaligned at start of fetch");

endmodule

`default_nettype wire

[rtl/core/encoder_frame_angle_decoder_top.sv]
// Top level of the encoder frame angle decoder.
//
//   channel   dir   payload                                        transfer when
//   req_bus   in    data_byte, frame_start                         valid && ready
//   rsp_bus   out   angle_index, angle_value, record_flag,         valid && ready
//                   checksum_error, last_result
//
// A byte is taken whenever valid is high and the decoder is not busy. After a
// frame's checksum byte the input stalls while results go out: an error result
// is offered the next cycle; a good frame gives eight results, each through
// three reads of the single store read port, a drain state for the last read
// data, the wrap, the multiply and the send state, which holds for any rsp stall.
// Synchronous reset returns to waiting for a header; the store needs no clear.
`default_nettype none

module encoder_frame_angle_decoder_top (
   input  wire logic  clock,
   input  wire logic  reset,
   efad_req_if.sink   req_bus,
   efad_rsp_if.source rsp_bus
);
   import efad_pkg::*;

   logic                    accept;
   logic                    busy;
   logic                    wr_en;
   logic [ADDR_W-1:0]       wr_addr;
   logic [BYTE_W-1:0]       wr_data;
   logic                    rd_en;
   logic [ADDR_W-1:0]       rd_addr;
   logic [BYTE_W-1:0]       rd_data;
   frame_evt_type           frame_evt;

   assign req_bus.ready = ~busy;
   assign accept        = req_bus.valid & ~busy;

   efad_intake u_intake (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_bus.data_byte),
      .frame_start (req_bus.frame_start),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .frame_evt   (frame_evt)
   );

   efad_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DATA_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   efad_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .frame_evt (frame_evt),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .busy      (busy),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire
